// File: rtl/core/irpft_pkg.sv
package irpft_pkg;

    // bits taken from each of the address and data bytes
    localparam int FIELD_BITS = 8;

    localparam int BYTE_W    = 8;
    localparam int DUR_W     = 16;
    localparam int REP_W     = 4;
    localparam int CW_BITS   = 4 * FIELD_BITS;
    localparam int CW_IDX_W  = $clog2(CW_BITS);
    localparam int STOP_POS  = 4 * FIELD_BITS;
    localparam int BP_W      = $clog2(STOP_POS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd7;

    typedef struct packed {
        logic [DUR_W-1:0] leader_high_ticks;
        logic [DUR_W-1:0] leader_low_ticks;
        logic [DUR_W-1:0] zero_high_ticks;
        logic [DUR_W-1:0] zero_low_ticks;
        logic [DUR_W-1:0] one_high_ticks;
        logic [DUR_W-1:0] one_low_ticks;
        logic [DUR_W-1:0] gap_ticks;
        logic [REP_W-1:0] repeat_total;
    } cfg_t;

    typedef struct packed {
        logic frame_done;
        logic request_dropped;
        logic busy_res;
        logic line_level;
    } res_t;

    function automatic logic [DUR_W-1:0] dur_at_least_one(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

    function automatic logic [REP_W-1:0] rep_at_least_one(input logic [REP_W-1:0] v);
        return (v == '0) ? REP_W'(1) : v;
    endfunction

    // address, ~address, data, ~data, lsb first
    function automatic logic [CW_BITS-1:0] build_code_word(
        input logic [BYTE_W-1:0] addr,
        input logic [BYTE_W-1:0] data
    );
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] d;
        a = FIELD_BITS'(addr);
        d = FIELD_BITS'(data);
        return {~d, d, ~a, a};
    endfunction

    // stop position and beyond send a one
    function automatic logic code_bit(
        input logic [CW_BITS-1:0] cw,
        input logic [BP_W-1:0]    pos
    );
        if (pos >= BP_W'(STOP_POS)) begin
            return 1'b1;
        end
        return cw[pos[CW_IDX_W-1:0]];
    endfunction

endpackage

// File: rtl/core/irpft_cfg_regs.sv
module irpft_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irpft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpft_pkg::CFG_DAT_W-1:0]    cfg_data,
    output irpft_pkg::cfg_t                    cfg
);
    import irpft_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LEADER_HIGH: cfg_next.leader_high_ticks = DUR_W'(cfg_data);
                CFG_LEADER_LOW:  cfg_next.leader_low_ticks  = DUR_W'(cfg_data);
                CFG_ZERO_HIGH:   cfg_next.zero_high_ticks   = DUR_W'(cfg_data);
                CFG_ZERO_LOW:    cfg_next.zero_low_ticks    = DUR_W'(cfg_data);
                CFG_ONE_HIGH:    cfg_next.one_high_ticks    = DUR_W'(cfg_data);
                CFG_ONE_LOW:     cfg_next.one_low_ticks     = DUR_W'(cfg_data);
                CFG_GAP:         cfg_next.gap_ticks         = DUR_W'(cfg_data);
                CFG_REPEAT:      cfg_next.repeat_total      = cfg_data[REP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_high_ticks <= DUR_W'(360);
            cfg_reg.leader_low_ticks  <= DUR_W'(180);
            cfg_reg.zero_high_ticks   <= DUR_W'(22);
            cfg_reg.zero_low_ticks    <= DUR_W'(23);
            cfg_reg.one_high_ticks    <= DUR_W'(45);
            cfg_reg.one_low_ticks     <= DUR_W'(45);
            cfg_reg.gap_ticks         <= DUR_W'(220);
            cfg_reg.repeat_total      <= REP_W'(6);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/irpft_sequencer.sv
module irpft_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic                               op,
    input  logic [irpft_pkg::BYTE_W-1:0]       address_byte,
    input  logic [irpft_pkg::BYTE_W-1:0]       data_byte,
    input  irpft_pkg::cfg_t                    cfg,
    output irpft_pkg::res_t                    res
);
    import irpft_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEAD_HI = 3'd1;
    localparam logic [2:0] PH_LEAD_LO = 3'd2;
    localparam logic [2:0] PH_BIT_HI  = 3'd3;
    localparam logic [2:0] PH_BIT_LO  = 3'd4;
    localparam logic [2:0] PH_GAP     = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic [DUR_W-1:0]   dur_reg,   dur_next;
    logic [BP_W-1:0]    bp_reg,    bp_next;
    logic [REP_W-1:0]   rep_reg,   rep_next;
    logic [CW_BITS-1:0] cw_reg,    cw_next;
    logic               end_word;

    always_comb begin
        phase_next = phase_reg;
        dur_next   = dur_reg;
        bp_next    = bp_reg;
        rep_next   = rep_reg;
        cw_next    = cw_reg;
        end_word   = 1'b0;
        res        = '0;
        if (step) begin
            // start request only taken while idle
            if (op) begin
                if (phase_next == PH_IDLE) begin
                    cw_next    = build_code_word(address_byte, data_byte);
                    rep_next   = '0;
                    bp_next    = '0;
                    phase_next = PH_LEAD_HI;
                    dur_next   = dur_at_least_one(cfg.leader_high_ticks);
                end else begin
                    res.request_dropped = 1'b1;
                end
            end
            if (phase_next != PH_IDLE) begin
                res.busy_res   = 1'b1;
                res.line_level = (phase_next == PH_LEAD_HI) || (phase_next == PH_BIT_HI);
                if (dur_next != '0) begin
                    dur_next = dur_next - DUR_W'(1);
                end
                if (dur_next == '0) begin
                    unique case (phase_next)
                        PH_LEAD_HI: begin
                            phase_next = PH_LEAD_LO;
                            dur_next   = dur_at_least_one(cfg.leader_low_ticks);
                        end
                        PH_LEAD_LO: begin
                            bp_next    = '0;
                            phase_next = PH_BIT_HI;
                            dur_next   = dur_at_least_one(code_bit(cw_next, '0) ?
                                         cfg.one_high_ticks : cfg.zero_high_ticks);
                        end
                        PH_BIT_HI: begin
                            phase_next = PH_BIT_LO;
                            dur_next   = dur_at_least_one(code_bit(cw_next, bp_next) ?
                                         cfg.one_low_ticks : cfg.zero_low_ticks);
                        end
                        PH_BIT_LO: begin
                            if (bp_next < BP_W'(STOP_POS)) begin
                                bp_next    = bp_next + BP_W'(1);
                                phase_next = PH_BIT_HI;
                                dur_next   = dur_at_least_one(code_bit(cw_next, bp_next) ?
                                             cfg.one_high_ticks : cfg.zero_high_ticks);
                            end else if (cfg.gap_ticks != '0) begin
                                phase_next = PH_GAP;
                                dur_next   = cfg.gap_ticks;
                            end else begin
                                end_word = 1'b1;
                            end
                        end
                        PH_GAP: begin
                            end_word = 1'b1;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            dur_next   = '0;
                        end
                    endcase
                    // code word finished: next repeat or end of frame
                    if (end_word) begin
                        rep_next = rep_next + REP_W'(1);
                        if (rep_next >= rep_at_least_one(cfg.repeat_total)) begin
                            phase_next     = PH_IDLE;
                            dur_next       = '0;
                            res.frame_done = 1'b1;
                        end else begin
                            bp_next    = '0;
                            phase_next = PH_BIT_HI;
                            dur_next   = dur_at_least_one(code_bit(cw_next, '0) ?
                                         cfg.one_high_ticks : cfg.zero_high_ticks);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            dur_reg   <= '0;
            bp_reg    <= '0;
            rep_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            dur_reg   <= dur_next;
            bp_reg    <= bp_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        cw_reg <= cw_next;
    end

endmodule

// File: rtl/core/ir_pulse_frame_transmitter_unit.sv
// an accepted input item's result item is in the output register in the next cycle
// throughput: one item per cycle; the frame sequencer updates its state in a single pass
// the output register frees on the same edge it is read, so the input side never stalls
// while the result side takes every item
// reset: synchronous, active low; clears the sequencer to idle, loads the register defaults
// and empties the output register
module ir_pulse_frame_transmitter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items, one per timer tick
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // address_byte[7:0], data_byte[15:8]
    input  logic                              s_tuser,   // op: 1 = tick with start request
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // line_level[0], busy_res[1],
                                                         // request_dropped[2], frame_done[3],
                                                         // zero[7:4]
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irpft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irpft_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import irpft_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       step;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;

    // take a new item whenever the output register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    irpft_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // leader, bit and gap timing plus the code word shift position
    irpft_sequencer u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .op           (s_tuser),
        .address_byte (s_tdata[7:0]),
        .data_byte    (s_tdata[15:8]),
        .cfg          (cfg),
        .res          (res)
    );

    // output register valid: set by each accepted item, cleared once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (step) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only with an accepted item
    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {4'b0000, res.frame_done, res.request_dropped,
                            res.busy_res, res.line_level};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/irpft_checker.sv
module irpft_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [7:0]                        m_tdata
);
    import irpft_pkg::*;

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // line only driven high inside a frame
    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("line high while not busy");

    // end of frame is reported on a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1])
        else $error("frame done outside a frame");

    // a dropped request can only come while a frame runs
    a_drop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("request dropped while idle");

endmodule

bind ir_pulse_frame_transmitter_unit irpft_checker u_irpft_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
